FILE: src/cts_pkg.sv
// Shared constants, types and calendar lookups for the date to seconds converter.
`timescale 1ns / 1ps

package cts_pkg;

    // Input field widths
    localparam int YEAR_W   = 16;
    localparam int FIELD_W  = 8;
    localparam int MONTH_W  = 4;
    localparam int EPOCH_W  = 32;

    // Calendar constants
    localparam logic [YEAR_W-1:0] EPOCH_YEAR         = 16'd1970;
    localparam logic [YEAR_W-1:0] LEAPS_BEFORE_EPOCH = 16'd477;  // leap years 1..1969
    localparam logic [7:0]        MONTH_FIRST        = 8'd1;
    localparam logic [7:0]        MONTH_LAST         = 8'd12;
    localparam logic [MONTH_W-1:0] MONTH_FEB         = 4'd2;

    // Reciprocal of 25 scaled by 2^20; exact floor for dividends below 43690
    localparam int               RECIP_SHIFT = 20;
    localparam logic [15:0]      RECIP_25    = 16'd41944;
    localparam int               Q100_W      = 10;   // year / 100 <= 655
    localparam int               Q400_W      = 8;    // year / 400 <= 163

    // Derived widths
    localparam int LEAPS_W = 14;   // leap years since 1970, <= 15414
    localparam int DOY_W   = 9;    // day of year, 0..365
    localparam int HMS_W   = 20;   // hour/minute/second seconds, <= 933555
    localparam int DAYS_W  = 25;   // days since epoch, < 2^25

    localparam logic [DOY_W-1:0] LAST_DOY = 9'd365;

    // Seconds per unit
    localparam logic [HMS_W-1:0]   SECS_PER_HOUR = 20'd3600;
    localparam logic [HMS_W-1:0]   SECS_PER_MIN  = 20'd60;
    localparam logic [EPOCH_W-1:0] SECS_PER_DAY  = 32'd86400;
    localparam logic [DAYS_W-1:0]  DAYS_PER_YEAR = 25'd365;

    // Beat passed from the date stages to the seconds stages
    typedef struct packed {
        logic                bad;
        logic [YEAR_W-1:0]   yoff;
        logic [LEAPS_W-1:0]  leaps;
        logic [DOY_W-1:0]    doy;
        logic [HMS_W-1:0]    hms;
    } t_date_beat;

    // Length of a month in a common year; zero for codes outside 1..12
    function automatic logic [4:0] f_month_len(input logic [MONTH_W-1:0] m);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                  len = 5'd30;
            4'd2:                                     len = 5'd28;
            default:                                  len = 5'd0;
        endcase
        return len;
    endfunction

    // Days of the whole months before month m in a common year
    function automatic logic [DOY_W-1:0] f_days_before(input logic [MONTH_W-1:0] m);
        logic [DOY_W-1:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

FILE: src/cts_date_stage.sv
// Date stages: validation, century quotients, leap count and day of year.
`timescale 1ns / 1ps

module cts_date_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [cts_pkg::YEAR_W-1:0]    i_year_full,
    input  logic [cts_pkg::FIELD_W-1:0]   i_month_num,
    input  logic [cts_pkg::FIELD_W-1:0]   i_day_num,
    input  logic [cts_pkg::FIELD_W-1:0]   i_hour_num,
    input  logic [cts_pkg::FIELD_W-1:0]   i_minute_num,
    input  logic [cts_pkg::FIELD_W-1:0]   i_second_num,
    output logic                          o_valid,
    input  logic                          i_ready,
    output cts_pkg::t_date_beat           o_beat
);
    import cts_pkg::*;

    // Stage A registers
    logic                  r_a_valid;
    logic                  r_a_bad;
    logic [YEAR_W-1:0]     r_a_year;
    logic [MONTH_W-1:0]    r_a_month;
    logic [FIELD_W-1:0]    r_a_day;
    logic [FIELD_W-1:0]    r_a_hour;
    logic [FIELD_W-1:0]    r_a_minute;
    logic [FIELD_W-1:0]    r_a_second;
    logic [Q100_W-1:0]     r_a_q100;
    logic [Q400_W-1:0]     r_a_q400;

    // Stage B registers
    logic                  r_b_valid;
    t_date_beat            r_b_beat;

    logic                  w_ready_a;
    logic                  w_ready_b;

    // Stage A combinational
    logic                  n_a_bad;
    logic [29:0]           w_p100;
    logic [27:0]           w_p400;

    // Stage B combinational
    logic                  w_z100;
    logic                  w_z400;
    logic                  w_leap;
    logic [YEAR_W-1:0]     w_year_m1;
    logic [YEAR_W-1:0]     w_leaps;
    logic [4:0]            w_dim;
    logic [FIELD_W-1:0]    w_day_clamp;
    logic [DOY_W-1:0]      w_doy;
    t_date_beat            n_b_beat;

    // Each stage moves when empty or when the next one moves
    assign w_ready_b = !r_b_valid || i_ready;
    assign w_ready_a = !r_a_valid || w_ready_b;
    assign o_ready   = w_ready_a;

    // Validation and year/100, year/400 by reciprocal multiply
    always_comb begin
        n_a_bad = (i_year_full < EPOCH_YEAR) || (i_month_num < MONTH_FIRST) ||
                  (i_month_num > MONTH_LAST) || (i_day_num == '0);
        w_p100  = 30'(i_year_full[YEAR_W-1:2]) * 30'(RECIP_25);
        w_p400  = 28'(i_year_full[YEAR_W-1:4]) * 28'(RECIP_25);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_ready_a) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_a && i_valid) begin
            r_a_bad    <= n_a_bad;
            r_a_year   <= i_year_full;
            r_a_month  <= i_month_num[MONTH_W-1:0];
            r_a_day    <= i_day_num;
            r_a_hour   <= i_hour_num;
            r_a_minute <= i_minute_num;
            r_a_second <= i_second_num;
            r_a_q100   <= w_p100[RECIP_SHIFT +: Q100_W];
            r_a_q400   <= w_p400[RECIP_SHIFT +: Q400_W];
        end
    end

    // Leap rule, leap count before this year, day of year, time of day
    always_comb begin
        w_z100 = (r_a_year[1:0] == 2'b00) &&
                 (r_a_year[YEAR_W-1:2] == 14'({4'b0, r_a_q100} * 14'd25));
        w_z400 = (r_a_year[3:0] == 4'b0000) &&
                 (r_a_year[YEAR_W-1:4] == 12'({4'b0, r_a_q400} * 12'd25));
        w_leap = (r_a_year[1:0] == 2'b00) && (!w_z100 || w_z400);

        // leaps through (year - 1): floor((y-1)/100) = year/100 - (year % 100 == 0)
        w_year_m1 = r_a_year - 16'd1;
        w_leaps   = {2'b00, w_year_m1[YEAR_W-1:2]}
                  - {6'b0, r_a_q100} + 16'(w_z100)
                  + {8'b0, r_a_q400} - 16'(w_z400)
                  - LEAPS_BEFORE_EPOCH;

        // Clamp the day to the month length
        w_dim = f_month_len(r_a_month) + 5'(w_leap && (r_a_month == MONTH_FEB));
        w_day_clamp = (r_a_day > {3'b0, w_dim}) ? {3'b0, w_dim} : r_a_day;
        w_doy = f_days_before(r_a_month)
              + 9'(w_leap && (r_a_month > MONTH_FEB))
              + {1'b0, w_day_clamp} - 9'd1;

        n_b_beat.bad   = r_a_bad;
        n_b_beat.yoff  = r_a_year - EPOCH_YEAR;
        n_b_beat.leaps = w_leaps[LEAPS_W-1:0];
        n_b_beat.doy   = w_doy;
        n_b_beat.hms   = 20'(r_a_hour) * SECS_PER_HOUR
                       + 20'(r_a_minute) * SECS_PER_MIN
                       + 20'(r_a_second);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (w_ready_b) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_b && r_a_valid) begin
            r_b_beat <= n_b_beat;
        end
    end

    assign o_valid = r_b_valid;
    assign o_beat  = r_b_beat;

`ifndef SYNTHESIS
    // A valid date never lands past the last day of a leap year
    a_doy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !r_b_beat.bad |-> r_b_beat.doy <= LAST_DOY)
        else $error("day of year out of range");

    // A blocked stage A keeps its transaction
    a_hold_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && !w_ready_b |=> r_a_valid && $stable(r_a_year))
        else $error("stage A lost a held transaction");

    // A transaction leaving stage A arrives in stage B
    a_move_ab: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && w_ready_b |=> r_b_valid)
        else $error("transaction dropped between stage A and B");
`endif

endmodule

FILE: src/cts_secs_stage.sv
// Seconds stages: days since epoch, then scaled to seconds with time of day added.
`timescale 1ns / 1ps

module cts_secs_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  cts_pkg::t_date_beat           i_beat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [cts_pkg::EPOCH_W-1:0]   o_epoch_seconds,
    output logic                          o_invalid
);
    import cts_pkg::*;

    // Stage C registers
    logic                  r_c_valid;
    logic                  r_c_bad;
    logic [DAYS_W-1:0]     r_c_days;
    logic [HMS_W-1:0]      r_c_hms;

    // Stage D (output) registers
    logic                  r_d_valid;
    logic                  r_d_bad;
    logic [EPOCH_W-1:0]    r_d_secs;

    logic                  w_ready_c;
    logic                  w_ready_d;
    logic [DAYS_W-1:0]     n_c_days;
    logic [EPOCH_W-1:0]    n_d_secs;

    assign w_ready_d = !r_d_valid || i_ready;
    assign w_ready_c = !r_c_valid || w_ready_d;
    assign o_ready   = w_ready_c;

    // Whole days since epoch
    assign n_c_days = 25'(i_beat.yoff) * DAYS_PER_YEAR
                    + 25'(i_beat.leaps) + 25'(i_beat.doy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_ready_c) begin
            r_c_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_c && i_valid) begin
            r_c_bad  <= i_beat.bad;
            r_c_days <= n_c_days;
            r_c_hms  <= i_beat.hms;
        end
    end

    // Seconds modulo 2^32; zero for a rejected date
    assign n_d_secs = r_c_bad ? '0
                    : (32'(r_c_days) * SECS_PER_DAY + 32'(r_c_hms));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
        end else if (w_ready_d) begin
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_d && r_c_valid) begin
            r_d_bad  <= r_c_bad;
            r_d_secs <= n_d_secs;
        end
    end

    assign o_valid         = r_d_valid;
    assign o_epoch_seconds = r_d_secs;
    assign o_invalid       = r_d_bad;

`ifndef SYNTHESIS
    // A rejected date always reads as zero seconds
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_valid && r_d_bad |-> r_d_secs == '0)
        else $error("invalid transaction with nonzero seconds");

    // A blocked stage C keeps its transaction
    a_hold_c: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && !w_ready_d |=> r_c_valid && $stable(r_c_days))
        else $error("stage C lost a held transaction");

    // A transaction leaving stage C arrives in the output register
    a_move_cd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_valid && w_ready_d |=> r_d_valid)
        else $error("transaction dropped between stage C and output");
`endif

endmodule

FILE: src/calendar_to_unix_seconds.sv
// Top level: Gregorian date and time to Unix seconds, four-stage pipeline.
//
//  channel   dir   handshake                 payload
//  s_axis    in    i_s_axis_tvalid/tready    tdata: year, month, day, hour, minute, second
//  m_axis    out   o_m_axis_tvalid/tready    tdata: epoch seconds; tuser: invalid flag
//
//  One transaction per cycle sustained while the output is ready; the result passes
//  through four register stages before it is offered.
//  Stages: input/quotient, leap count and day of year, day count, seconds and output.
//  Each stage advances when empty or when the stage after it advances, so a stall
//  on the output backs up the pipe without loss or repetition.
//  Reset (i_rst_n low, synchronous) empties all stages; no clearing pass is needed.
`timescale 1ns / 1ps

module calendar_to_unix_seconds (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [15:0] year_full, [23:16] month_num, [31:24] day_num,
    // [39:32] hour_num, [47:40] minute_num, [55:48] second_num
    input  logic [55:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] epoch_seconds
    output logic [31:0] o_m_axis_tdata,
    // [0] invalid
    output logic        o_m_axis_tuser
);
    import cts_pkg::*;

    logic        w_mid_valid;
    logic        w_mid_ready;
    t_date_beat  w_mid_beat;

    cts_date_stage u_date (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_year_full  (i_s_axis_tdata[15:0]),
        .i_month_num  (i_s_axis_tdata[23:16]),
        .i_day_num    (i_s_axis_tdata[31:24]),
        .i_hour_num   (i_s_axis_tdata[39:32]),
        .i_minute_num (i_s_axis_tdata[47:40]),
        .i_second_num (i_s_axis_tdata[55:48]),
        .o_valid      (w_mid_valid),
        .i_ready      (w_mid_ready),
        .o_beat       (w_mid_beat)
    );

    cts_secs_stage u_secs (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_mid_valid),
        .o_ready         (w_mid_ready),
        .i_beat          (w_mid_beat),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_epoch_seconds (o_m_axis_tdata),
        .o_invalid       (o_m_axis_tuser)
    );

endmodule
